// ===== hw/rtl/tccw_pkg.sv =====
`default_nettype none

package tccw_pkg;

    // screen geometry
    localparam int ROWS  = 25;
    localparam int COLS  = 80;
    localparam int ROW_W = 5;
    localparam int COL_W = 7;

    // one cell: character in the low byte, attribute in the high byte
    localparam int CHAR_W = 8;
    localparam int ATTR_W = 8;
    localparam int CELL_W = CHAR_W + ATTR_W;

    // cell ram is addressed {physical row, column}
    localparam int ADDR_W    = ROW_W + COL_W;
    localparam int MEM_DEPTH = ROWS * (2 ** COL_W);

    localparam logic [CHAR_W-1:0] NEWLINE_CODE     = 8'd10;
    localparam logic [ATTR_W-1:0] DEF_ATTR_RST     = 8'd15;

    localparam logic CMD_PUT  = 1'b0;
    localparam logic CMD_READ = 1'b1;

    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);
    localparam logic [COL_W-1:0] LAST_COL = COL_W'(COLS - 1);

    // logical row to physical row, given the physical row shown at the top
    function automatic logic [ROW_W-1:0] phys_row(
        input logic [ROW_W-1:0] lrow,
        input logic [ROW_W-1:0] top
    );
        logic [ROW_W:0] sum;
        sum = {1'b0, lrow} + {1'b0, top};
        if (sum >= (ROW_W+1)'(ROWS)) begin
            sum = sum - (ROW_W+1)'(ROWS);
        end
        return sum[ROW_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/tccw_ram.sv =====
`default_nettype none

module tccw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire  [$clog2(DEPTH)-1:0] i_waddr,
    input  wire  [WIDTH-1:0]         i_wdata,
    input  wire                      i_re,
    input  wire  [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/text_console_char_writer_top.sv =====
`default_nettype none

// text console cell store with a cursor. each input word is a put (write a character
// and attribute at the cursor or at a given row and column, newline moves to the next
// row) or a read of one cell; every input word yields exactly one output word that
// carries the read cell (zero for a put), the cursor after the word and a scroll flag.
// rows and columns beyond the screen saturate to the last row and column. the screen
// is kept as a circular buffer of rows in a single-port-write ram, so a scroll only
// blanks the row that comes round to the bottom and advances the top-row pointer.
// flow: an accepted put or read goes through the finish state, which loads the output
// register once the output is free; the next word is taken only after that, so a word
// is not taken while the last one is in progress. a put that scrolls first blanks the
// row, one cell per cycle through the ram write port. after reset a clearing pass
// blanks the whole screen, ROWS*COLS cells, during which no input word is taken;
// configuration writes are taken at any time. the output register lets the next
// word be accepted while the previous result is still waiting.

module text_console_char_writer_top (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // configuration: default_attribute [7:0]
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [7:0]  i_cfg_data,
    // input words
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // character [7:0], attribute [15:8], at_position [16], row [21:17], col [28:22]
    input  wire  [31:0] i_s_axis_tdata,
    // command [0]
    input  wire  [0:0]  i_s_axis_tuser,
    // output words
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    // cell_char [7:0], cell_attribute [15:8], cursor_row [20:16], cursor_col [27:21],
    // scrolled [28]
    output logic [31:0] o_m_axis_tdata
);

    import tccw_pkg::*;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_FINISH
    } t_state;

    // unpacked input word
    logic              in_cmd;
    logic [CHAR_W-1:0] in_char;
    logic [ATTR_W-1:0] in_attr;
    logic              in_at_pos;
    logic [ROW_W-1:0]  in_row;
    logic [COL_W-1:0]  in_col;

    assign in_cmd    = i_s_axis_tuser[0];
    assign in_char   = i_s_axis_tdata[7:0];
    assign in_attr   = i_s_axis_tdata[15:8];
    assign in_at_pos = i_s_axis_tdata[16];
    assign in_row    = i_s_axis_tdata[21:17];
    assign in_col    = i_s_axis_tdata[28:22];

    // registers
    t_state            r_state,    n_state;
    logic [ATTR_W-1:0] r_def_attr, n_def_attr;
    logic [ROW_W-1:0]  r_top,      n_top;       // physical row shown as row 0
    logic [ROW_W-1:0]  r_cur_row,  n_cur_row;
    logic [COL_W-1:0]  r_cur_col,  n_cur_col;
    logic [ROW_W-1:0]  r_clr_row,  n_clr_row;   // physical row being blanked
    logic [COL_W-1:0]  r_clr_col,  n_clr_col;
    logic              r_clr_all,  n_clr_all;   // reset pass over every row
    logic              r_is_read,  n_is_read;
    logic              r_scrolled, n_scrolled;
    logic              r_out_vld,  n_out_vld;
    logic [31:0]       r_out_data, n_out_data;

    // ram ports
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [CELL_W-1:0] ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [CELL_W-1:0] ram_rdata;

    // item decode
    logic              accept;
    logic              out_free;
    logic [ROW_W-1:0]  row_sat;
    logic [COL_W-1:0]  col_sat;
    logic [ROW_W-1:0]  tgt_row;
    logic [COL_W-1:0]  tgt_col;
    logic [ADDR_W-1:0] tgt_addr;
    logic [ATTR_W-1:0] attr_eff;
    logic              is_newline;
    logic [ROW_W:0]    nxt_row;
    logic [COL_W-1:0]  nxt_col;
    logic              do_scroll;

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = r_out_data;

    assign accept   = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free = !r_out_vld || i_m_axis_tready;

    always_comb begin
        row_sat = (in_row >= ROW_W'(ROWS)) ? LAST_ROW : in_row;
        col_sat = (in_col >= COL_W'(COLS)) ? LAST_COL : in_col;

        // a read always uses the given position
        if (in_cmd == CMD_READ || in_at_pos) begin
            tgt_row = row_sat;
            tgt_col = col_sat;
        end else begin
            tgt_row = r_cur_row;
            tgt_col = r_cur_col;
        end
        tgt_addr = {phys_row(tgt_row, r_top), tgt_col};

        attr_eff   = (in_attr == '0) ? r_def_attr : in_attr;
        is_newline = (in_char == NEWLINE_CODE);

        // cursor after a put; a row of ROWS means the screen scrolls
        if (is_newline || tgt_col == LAST_COL) begin
            nxt_row = {1'b0, tgt_row} + (ROW_W+1)'(1);
            nxt_col = '0;
        end else begin
            nxt_row = {1'b0, tgt_row};
            nxt_col = tgt_col + COL_W'(1);
        end
        do_scroll = (nxt_row == (ROW_W+1)'(ROWS));
    end

    // ram access: blanking sweep, or the put / read of an accepted word
    always_comb begin
        if (r_state == S_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = {r_clr_row, r_clr_col};
            ram_wdata = '0;
        end else begin
            ram_we    = accept && (in_cmd == CMD_PUT) && !is_newline;
            ram_waddr = tgt_addr;
            ram_wdata = {attr_eff, in_char};
        end
        ram_re    = accept && (in_cmd == CMD_READ);
        ram_raddr = tgt_addr;
    end

    always_comb begin
        n_state    = r_state;
        n_def_attr = r_def_attr;
        n_top      = r_top;
        n_cur_row  = r_cur_row;
        n_cur_col  = r_cur_col;
        n_clr_row  = r_clr_row;
        n_clr_col  = r_clr_col;
        n_clr_all  = r_clr_all;
        n_is_read  = r_is_read;
        n_scrolled = r_scrolled;
        n_out_vld  = r_out_vld && !i_m_axis_tready;
        n_out_data = r_out_data;

        if (i_cfg_valid) begin
            n_def_attr = i_cfg_data;
        end

        case (r_state)
            S_CLEAR: begin
                if (r_clr_col == LAST_COL) begin
                    n_clr_col = '0;
                    if (r_clr_all) begin
                        if (r_clr_row == LAST_ROW) begin
                            n_clr_all = 1'b0;
                            n_state   = S_IDLE;
                        end else begin
                            n_clr_row = r_clr_row + ROW_W'(1);
                        end
                    end else begin
                        // blanked row becomes the bottom row
                        n_top   = (r_top == LAST_ROW) ? '0 : r_top + ROW_W'(1);
                        n_state = S_FINISH;
                    end
                end else begin
                    n_clr_col = r_clr_col + COL_W'(1);
                end
            end
            S_IDLE: begin
                if (accept) begin
                    if (in_cmd == CMD_READ) begin
                        n_is_read  = 1'b1;
                        n_scrolled = 1'b0;
                        n_state    = S_FINISH;
                    end else begin
                        n_is_read  = 1'b0;
                        n_scrolled = do_scroll;
                        n_cur_col  = nxt_col;
                        if (do_scroll) begin
                            n_cur_row = LAST_ROW;
                            n_clr_row = r_top;
                            n_clr_col = '0;
                            n_state   = S_CLEAR;
                        end else begin
                            n_cur_row = nxt_row[ROW_W-1:0];
                            n_state   = S_FINISH;
                        end
                    end
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    n_out_vld  = 1'b1;
                    n_out_data = {3'b000, r_scrolled, r_cur_col, r_cur_row,
                                  r_is_read ? ram_rdata : {CELL_W{1'b0}}};
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_def_attr <= DEF_ATTR_RST;
            r_top      <= '0;
            r_cur_row  <= '0;
            r_cur_col  <= '0;
            r_clr_row  <= '0;
            r_clr_col  <= '0;
            r_clr_all  <= 1'b1;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_def_attr <= n_def_attr;
            r_top      <= n_top;
            r_cur_row  <= n_cur_row;
            r_cur_col  <= n_cur_col;
            r_clr_row  <= n_clr_row;
            r_clr_col  <= n_clr_col;
            r_clr_all  <= n_clr_all;
            r_out_vld  <= n_out_vld;
            r_is_read  <= n_is_read;
            r_scrolled <= n_scrolled;
            r_out_data <= n_out_data;
        end
    end

    tccw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (MEM_DEPTH)
    ) u_cells (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

endmodule

`default_nettype wire
